// File: src/bpj_pkg.sv
// Shared constants, register codes and types of the depth pixel back-projector.
`default_nettype none

package bpj_pkg;

    // Image and label geometry.
    localparam int FRAME_COLS     = 640;
    localparam int FRAME_ROWS     = 480;
    localparam int LABEL_CHANNELS = 3;
    localparam int LABEL_WORDS    = 3;

    // Field widths.
    localparam int COL_W     = 10;
    localparam int ROW_W     = 9;
    localparam int DIM_W     = 13;
    localparam int RAW_W     = 16;
    localparam int LABEL_W   = 16;
    localparam int RECIP_W   = 24;
    localparam int PRIN_W    = 14;
    localparam int EXT_W     = 64;
    localparam int COEF_W    = 16;
    localparam int OUT_W     = 24;
    localparam int CFG_IDX_W = 3;

    // Internal datapath widths.
    localparam int DPROD_W = RAW_W + RECIP_W;      // raw depth times scale
    localparam int DEPTH_W = DPROD_W - 8;          // Q16.16 depth
    localparam int SPROD_W = DEPTH_W + RECIP_W;    // depth times 1/f
    localparam int SCALE_W = SPROD_W - 16;         // Q.24 scale
    localparam int OFF_W   = COL_W + 5;            // signed Q.4 pixel offset
    localparam int CPROD_W = OFF_W + SCALE_W + 1;  // offset times scale
    localparam int CAM_W   = 43;                   // signed Q.16 camera coordinate
    localparam int PROD_W  = COEF_W + CAM_W;       // coefficient times coordinate
    localparam int ACC_W   = PROD_W + 3;           // row sum at Q.28

    // Saturation bounds of a Q8.16 output coordinate.
    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -24'sh800000;

    // Work queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Register reset values.
    localparam logic [RECIP_W-1:0] RST_DEPTH_SCALE_RECIP = 24'd16777;
    localparam logic [RECIP_W-1:0] RST_INV_FOCAL         = 24'd27962;
    localparam logic [PRIN_W-1:0]  RST_PRINCIPAL_X       = 14'd5120;
    localparam logic [PRIN_W-1:0]  RST_PRINCIPAL_Y       = 14'd3840;
    localparam logic [EXT_W-1:0]   RST_EXT_ROW0          = 64'd4096;
    localparam logic [EXT_W-1:0]   RST_EXT_ROW1          = 64'd268435456;
    localparam logic [EXT_W-1:0]   RST_EXT_ROW2          = 64'd17592186044416;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_SCALE_RECIP = 3'd0,
        REG_INV_FOCAL_X       = 3'd1,
        REG_INV_FOCAL_Y       = 3'd2,
        REG_PRINCIPAL_X       = 3'd3,
        REG_PRINCIPAL_Y       = 3'd4,
        REG_EXTRINSIC_ROW0    = 3'd5,
        REG_EXTRINSIC_ROW1    = 3'd6,
        REG_EXTRINSIC_ROW2    = 3'd7
    } cfg_reg_t;

    // One accepted pixel that yields a point.
    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [DEPTH_W-1:0] depth;
    } work_t;

    // Camera settings seen by the back end.
    typedef struct packed {
        logic [RECIP_W-1:0]          inv_focal_x;
        logic [RECIP_W-1:0]          inv_focal_y;
        logic [PRIN_W-1:0]           principal_x;
        logic [PRIN_W-1:0]           principal_y;
        logic [2:0][EXT_W-1:0]       ext_row;
    } cam_cfg_t;

endpackage

`default_nettype wire

// File: src/bpj_if.sv
// Handshake interfaces for the pixel, point and configuration channels.
`default_nettype none

interface bpj_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [bpj_pkg::COL_W-1:0]     pixel_col;
    logic [bpj_pkg::ROW_W-1:0]     pixel_row;
    logic [bpj_pkg::RAW_W-1:0]     depth_raw;
    logic [bpj_pkg::LABEL_W-1:0]   label_ch1;
    logic [bpj_pkg::LABEL_W-1:0]   label_ch2;
    logic [bpj_pkg::LABEL_W-1:0]   label_ch3;

    modport source (output valid, pixel_col, pixel_row, depth_raw,
                    label_ch1, label_ch2, label_ch3, input ready);
    modport sink   (input valid, pixel_col, pixel_row, depth_raw,
                    label_ch1, label_ch2, label_ch3, output ready);
endinterface

interface bpj_point_if;
    logic                              valid;
    logic                              ready;
    logic signed [bpj_pkg::OUT_W-1:0]  point_x;
    logic signed [bpj_pkg::OUT_W-1:0]  point_y;
    logic signed [bpj_pkg::OUT_W-1:0]  point_z;
    logic                              clipped;

    modport source (output valid, point_x, point_y, point_z, clipped, input ready);
    modport sink   (input valid, point_x, point_y, point_z, clipped, output ready);
endinterface

interface bpj_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bpj_pkg::CFG_IDX_W-1:0]     index;
    logic [bpj_pkg::EXT_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/masked_depth_pixel_backprojector.sv
// Top level of the masked depth pixel back-projector.
//
//   channel  modport  word
//   -------  -------  --------------------------------------------------------
//   pixel    sink     pixel_col, pixel_row, depth_raw, label_ch1..label_ch3
//   point    source   point_x, point_y, point_z, clipped
//   cfg      sink     index, data (register write)
//
// One pixel is accepted per clock unless a kept word in the front stage waits on a
// full queue. A kept pixel is captured in the front stage when accepted, enters the
// work queue, and passes back stages 1 to 4 and the output register before it is
// offered as a point. A dropped pixel leaves at the front stage. Reset clears all
// valid state and loads the register reset values. A stall on point freezes the
// back pipeline; the four-word queue then fills before the pixel channel stalls.
`default_nettype none

module masked_depth_pixel_backprojector (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bpj_pixel_if.sink    pixel,
    bpj_point_if.source  point,
    bpj_cfg_if.sink      cfg
);

    logic [bpj_pkg::RECIP_W-1:0] depth_scale_recip_reg;
    bpj_pkg::cam_cfg_t           cam_cfg_reg;

    logic                        push_valid, push_ready;
    bpj_pkg::work_t              push_data;
    logic                        pop_valid, pop_ready;
    bpj_pkg::work_t              pop_data;

    assign cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_scale_recip_reg   <= bpj_pkg::RST_DEPTH_SCALE_RECIP;
            cam_cfg_reg.inv_focal_x <= bpj_pkg::RST_INV_FOCAL;
            cam_cfg_reg.inv_focal_y <= bpj_pkg::RST_INV_FOCAL;
            cam_cfg_reg.principal_x <= bpj_pkg::RST_PRINCIPAL_X;
            cam_cfg_reg.principal_y <= bpj_pkg::RST_PRINCIPAL_Y;
            cam_cfg_reg.ext_row[0]  <= bpj_pkg::RST_EXT_ROW0;
            cam_cfg_reg.ext_row[1]  <= bpj_pkg::RST_EXT_ROW1;
            cam_cfg_reg.ext_row[2]  <= bpj_pkg::RST_EXT_ROW2;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (bpj_pkg::cfg_reg_t'(cfg.index))
                bpj_pkg::REG_DEPTH_SCALE_RECIP:
                    depth_scale_recip_reg <= cfg.data[bpj_pkg::RECIP_W-1:0];
                bpj_pkg::REG_INV_FOCAL_X:
                    cam_cfg_reg.inv_focal_x <= cfg.data[bpj_pkg::RECIP_W-1:0];
                bpj_pkg::REG_INV_FOCAL_Y:
                    cam_cfg_reg.inv_focal_y <= cfg.data[bpj_pkg::RECIP_W-1:0];
                bpj_pkg::REG_PRINCIPAL_X:
                    cam_cfg_reg.principal_x <= cfg.data[bpj_pkg::PRIN_W-1:0];
                bpj_pkg::REG_PRINCIPAL_Y:
                    cam_cfg_reg.principal_y <= cfg.data[bpj_pkg::PRIN_W-1:0];
                bpj_pkg::REG_EXTRINSIC_ROW0:
                    cam_cfg_reg.ext_row[0] <= cfg.data;
                bpj_pkg::REG_EXTRINSIC_ROW1:
                    cam_cfg_reg.ext_row[1] <= cfg.data;
                bpj_pkg::REG_EXTRINSIC_ROW2:
                    cam_cfg_reg.ext_row[2] <= cfg.data;
                default:
                    depth_scale_recip_reg <= depth_scale_recip_reg;
            endcase
        end
    end

    // Front end.
    bpj_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .pixel             (pixel),
        .depth_scale_recip (depth_scale_recip_reg),
        .push_valid        (push_valid),
        .push_data         (push_data),
        .push_ready        (push_ready)
    );

    // Work queue.
    bpj_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    // Back end.
    bpj_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cam_cfg   (cam_cfg_reg),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .point     (point)
    );

endmodule

`default_nettype wire

// File: src/bpj_front.sv
// Front end: accepts pixels, scales depth and drops pixels that yield no point.
`default_nettype none

module bpj_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    bpj_pixel_if.sink                             pixel,
    input  wire logic [bpj_pkg::RECIP_W-1:0]      depth_scale_recip,
    output logic                                  push_valid,
    output bpj_pkg::work_t                        push_data,
    input  wire logic                             push_ready
);

    logic                         hold_valid_reg, hold_valid_next;
    logic                         hold_keep_reg,  hold_keep_next;
    bpj_pkg::work_t               hold_data_reg,  hold_data_next;
    logic [bpj_pkg::DPROD_W-1:0]  depth_prod;
    logic                         in_image;
    logic                         label_found;

    // The held word leaves when the queue takes it or when it is dropped.
    assign pixel.ready = !hold_valid_reg || !hold_keep_reg || push_ready;
    assign push_valid  = hold_valid_reg && hold_keep_reg;
    assign push_data   = hold_data_reg;

    // Depth scaling and classification of the incoming word.
    always_comb
    begin
        logic [bpj_pkg::LABEL_W-1:0] labels [bpj_pkg::LABEL_WORDS];
        labels[0] = pixel.label_ch1;
        labels[1] = pixel.label_ch2;
        labels[2] = pixel.label_ch3;
        depth_prod = bpj_pkg::DPROD_W'(pixel.depth_raw) *
                     bpj_pkg::DPROD_W'(depth_scale_recip);
        in_image = (bpj_pkg::DIM_W'(pixel.pixel_col) < bpj_pkg::DIM_W'(bpj_pkg::FRAME_COLS)) &&
                   (bpj_pkg::DIM_W'(pixel.pixel_row) < bpj_pkg::DIM_W'(bpj_pkg::FRAME_ROWS));
        label_found = 1'b0;
        for (int i = 0; i < bpj_pkg::LABEL_WORDS; i++)
        begin
            if (i < bpj_pkg::LABEL_CHANNELS && labels[i] != '0)
            begin
                label_found = 1'b1;
            end
        end
        hold_data_next.col   = pixel.pixel_col;
        hold_data_next.row   = pixel.pixel_row;
        hold_data_next.depth = depth_prod[bpj_pkg::DPROD_W-1:8];
        hold_keep_next  = in_image && label_found && (hold_data_next.depth != '0);
        hold_valid_next = pixel.ready ? pixel.valid : hold_valid_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Held word.
    always_ff @(posedge clk)
    begin
        if (pixel.valid && pixel.ready)
        begin
            hold_keep_reg <= hold_keep_next;
            hold_data_reg <= hold_data_next;
        end
    end

endmodule

`default_nettype wire

// File: src/bpj_fifo.sv
// Short work queue that decouples the front end from the back end.
`default_nettype none

module bpj_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    input  wire bpj_pkg::work_t  push_data,
    output logic                 push_ready,
    output logic                 pop_valid,
    output bpj_pkg::work_t       pop_data,
    input  wire logic            pop_ready
);

    bpj_pkg::work_t              slot_reg [bpj_pkg::QUEUE_DEPTH];
    logic [bpj_pkg::QPTR_W:0]    wr_ptr_reg, wr_ptr_next;
    logic [bpj_pkg::QPTR_W:0]    rd_ptr_reg, rd_ptr_next;
    logic                        do_push, do_pop;

    // Full when the pointers differ only in the wrap bit.
    assign push_ready = !((wr_ptr_reg[bpj_pkg::QPTR_W] != rd_ptr_reg[bpj_pkg::QPTR_W]) &&
                          (wr_ptr_reg[bpj_pkg::QPTR_W-1:0] == rd_ptr_reg[bpj_pkg::QPTR_W-1:0]));
    assign pop_valid  = (wr_ptr_reg != rd_ptr_reg);
    assign pop_data   = slot_reg[rd_ptr_reg[bpj_pkg::QPTR_W-1:0]];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg[bpj_pkg::QPTR_W-1:0]] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: src/bpj_back.sv
// Back end: five-stage back-projection and body frame transform pipeline.
`default_nettype none

module bpj_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bpj_pkg::cam_cfg_t cam_cfg,
    input  wire logic              pop_valid,
    input  wire bpj_pkg::work_t    pop_data,
    output logic                   pop_ready,
    bpj_point_if.source            point
);

    localparam int CW = bpj_pkg::CAM_W;
    localparam int PW = bpj_pkg::PROD_W;
    localparam int AW = bpj_pkg::ACC_W;
    localparam int OW = bpj_pkg::OUT_W;

    logic advance;

    // Stage valids and output valid.
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    // Stage 1: scale factors and pixel offsets.
    logic [bpj_pkg::SCALE_W-1:0]        sx_reg, sy_reg, sx_next, sy_next;
    logic signed [bpj_pkg::OFF_W-1:0]   offx_reg, offy_reg, offx_next, offy_next;
    logic [bpj_pkg::DEPTH_W-1:0]        d1_reg;
    logic [bpj_pkg::SPROD_W-1:0]        mx, my;

    // Stage 2: camera frame coordinates.
    logic signed [CW-1:0]               cam_reg [3];
    logic signed [CW-1:0]               cam_next [3];
    logic signed [bpj_pkg::CPROD_W-1:0] cpx, cpy;

    // Stage 3: rotation products and translations.
    logic signed [PW-1:0]               prod_reg [3][3];
    logic signed [PW-1:0]               prod_next [3][3];
    logic signed [bpj_pkg::COEF_W-1:0]  tr_reg [3];
    logic signed [bpj_pkg::COEF_W-1:0]  tr_next [3];

    // Stage 4: row sums.
    logic signed [AW-1:0]               acc_reg [3];
    logic signed [AW-1:0]               acc_next [3];

    // Output register.
    logic signed [OW-1:0]               pt_reg [3];
    logic signed [OW-1:0]               pt_next [3];
    logic                               clip_reg, clip_next;

    // The whole pipeline moves when the output register can take a word.
    assign advance   = !out_valid_reg || point.ready;
    assign pop_ready = advance;

    assign point.valid   = out_valid_reg;
    assign point.point_x = pt_reg[0];
    assign point.point_y = pt_reg[1];
    assign point.point_z = pt_reg[2];
    assign point.clipped = clip_reg;

    // Stage 1 logic.
    always_comb
    begin
        mx = bpj_pkg::SPROD_W'(pop_data.depth) * bpj_pkg::SPROD_W'(cam_cfg.inv_focal_x);
        my = bpj_pkg::SPROD_W'(pop_data.depth) * bpj_pkg::SPROD_W'(cam_cfg.inv_focal_y);
        sx_next = mx[bpj_pkg::SPROD_W-1:16];
        sy_next = my[bpj_pkg::SPROD_W-1:16];
        offx_next = $signed({1'b0, pop_data.col, 4'b0000}) -
                    $signed({1'b0, cam_cfg.principal_x});
        offy_next = $signed(bpj_pkg::OFF_W'({pop_data.row, 4'b0000})) -
                    $signed({1'b0, cam_cfg.principal_y});
    end

    // Stage 2 logic: floored shift of offset times scale.
    always_comb
    begin
        cpx = offx_reg * $signed({1'b0, sx_reg});
        cpy = offy_reg * $signed({1'b0, sy_reg});
        cam_next[0] = CW'(cpx >>> 12);
        cam_next[1] = CW'(cpy >>> 12);
        cam_next[2] = $signed(CW'(d1_reg));
    end

    // Stage 3 logic: nine coefficient products.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[i][k] = $signed(cam_cfg.ext_row[i][16*k +: 16]) * cam_reg[k];
            end
            tr_next[i] = $signed(cam_cfg.ext_row[i][48 +: 16]);
        end
    end

    // Stage 4 logic: sum each row with its translation at Q.28.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = AW'(prod_reg[i][0]) + AW'(prod_reg[i][1]) + AW'(prod_reg[i][2]) +
                          (AW'(tr_reg[i]) <<< 16);
        end
    end

    // Output logic: floor to Q.16 and saturate.
    always_comb
    begin
        logic signed [AW-1:0] sh;
        clip_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sh = acc_reg[i] >>> 12;
            if (sh > AW'(bpj_pkg::OUT_MAX))
            begin
                pt_next[i] = bpj_pkg::OUT_MAX;
                clip_next  = 1'b1;
            end
            else if (sh < AW'(bpj_pkg::OUT_MIN))
            begin
                pt_next[i] = bpj_pkg::OUT_MIN;
                clip_next  = 1'b1;
            end
            else
            begin
                pt_next[i] = OW'(sh);
            end
        end
    end

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= pop_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            offx_reg <= offx_next;
            offy_reg <= offy_next;
            d1_reg   <= pop_data.depth;
            for (int i = 0; i < 3; i++)
            begin
                cam_reg[i] <= cam_next[i];
                tr_reg[i]  <= tr_next[i];
                acc_reg[i] <= acc_next[i];
                pt_reg[i]  <= pt_next[i];
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[i][k] <= prod_next[i][k];
                end
            end
            clip_reg <= clip_next;
        end
    end

endmodule

`default_nettype wire

// File: src/bpj_checker.sv
// Port-level assertions for the back-projector and the bind that attaches them.
`default_nettype none

module bpj_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic signed [bpj_pkg::OUT_W-1:0] point_x,
    input wire logic signed [bpj_pkg::OUT_W-1:0] point_y,
    input wire logic signed [bpj_pkg::OUT_W-1:0] point_z,
    input wire logic                             clipped,
    input wire logic                             cfg_valid,
    input wire logic                             cfg_ready
);

    // A clipped point has at least one coordinate at a saturation bound.
    a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clipped) |->
            (point_x == bpj_pkg::OUT_MAX || point_x == bpj_pkg::OUT_MIN ||
             point_y == bpj_pkg::OUT_MAX || point_y == bpj_pkg::OUT_MIN ||
             point_z == bpj_pkg::OUT_MAX || point_z == bpj_pkg::OUT_MIN))
        else $error("clipped point without a saturated coordinate");

    // A stalled point keeps its valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("point valid dropped while stalled");

    // A stalled point keeps its word.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            ($stable(point_x) && $stable(point_y) && $stable(point_z) && $stable(clipped)))
        else $error("point word changed while stalled");

    // Register writes are never refused out of reset.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind masked_depth_pixel_backprojector bpj_checker u_bpj_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (point.valid),
    .out_ready (point.ready),
    .point_x   (point.point_x),
    .point_y   (point.point_y),
    .point_z   (point.point_z),
    .clipped   (point.clipped),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

`default_nettype wire

// File: bench/bpj_point_checker.sv
// Watches the pixel, point and register channels, predicts each body frame point and compares.
`timescale 1ns / 100ps

module bpj_point_checker
    import bpj_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    bpj_pixel_if  pixel,
    bpj_point_if  point,
    bpj_cfg_if    cfg,
    output int    fail_count,
    output int    pending
);

    // One body frame point as it leaves the point channel.
    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    clipped;
    } body_point_t;

    // Shadow copy of the camera registers.
    logic [RECIP_W-1:0] depth_scale;
    logic [RECIP_W-1:0] inv_fx;
    logic [RECIP_W-1:0] inv_fy;
    logic [PRIN_W-1:0]  cx;
    logic [PRIN_W-1:0]  cy;
    logic [EXT_W-1:0]   ext_row [3];

    body_point_t expected_points [$];
    body_point_t want;
    body_point_t got;
    body_point_t projected;

    // Pinhole back-projection of one axis, result in signed Q.16 metres.
    function automatic longint camera_axis(input logic [COL_W-1:0] pix,
                                           input logic [PRIN_W-1:0] principal,
                                           input logic [63:0] depth,
                                           input logic [RECIP_W-1:0] inv_f);
        longint offset;
        longint scale;
        offset = longint'({pix, 4'b0000}) - longint'(principal);
        scale  = longint'((depth * 64'(inv_f)) >> 16);
        return (offset * scale) >>> 12;
    endfunction

    // Returns 1 and the point when the pixel is kept, 0 when it is dropped.
    function automatic bit project_pixel(input logic [COL_W-1:0] col,
                                         input logic [ROW_W-1:0] row,
                                         input logic [RAW_W-1:0] raw,
                                         input logic [LABEL_W-1:0] lab1,
                                         input logic [LABEL_W-1:0] lab2,
                                         input logic [LABEL_W-1:0] lab3,
                                         output body_point_t pt);
        logic [63:0]             depth;
        logic [LABEL_W-1:0]      labels [3];
        longint                  cam [3];
        longint                  acc;
        longint                  coef;
        longint                  level;
        logic signed [OUT_W-1:0] coord [3];
        bit                      labelled;
        bit                      clip;
        pt = '0;
        labels[0] = lab1;
        labels[1] = lab2;
        labels[2] = lab3;
        if (col >= FRAME_COLS || row >= FRAME_ROWS)
            return 1'b0;
        depth = (64'(raw) * 64'(depth_scale)) >> 8;
        if (depth == 0)
            return 1'b0;
        labelled = 1'b0;
        for (int k = 0; k < LABEL_WORDS && k < LABEL_CHANNELS; k++)
            if (labels[k] != 0)
                labelled = 1'b1;
        if (!labelled)
            return 1'b0;

        cam[0] = camera_axis(col, cx, depth, inv_fx);
        cam[1] = camera_axis(COL_W'(row), cy, depth, inv_fy);
        cam[2] = longint'(depth);

        // Rotation plus translation at Q.28, floored back to Q.16 and saturated.
        clip = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            coef = $signed(ext_row[r][48 +: 16]);
            acc  = coef <<< 16;
            for (int k = 0; k < 3; k++)
            begin
                coef = $signed(ext_row[r][16*k +: 16]);
                acc  = acc + coef * cam[k];
            end
            level = acc >>> 12;
            if (level > OUT_MAX)
            begin
                level = OUT_MAX;
                clip  = 1'b1;
            end
            else if (level < OUT_MIN)
            begin
                level = OUT_MIN;
                clip  = 1'b1;
            end
            coord[r] = level[OUT_W-1:0];
        end
        pt.x       = coord[0];
        pt.y       = coord[1];
        pt.z       = coord[2];
        pt.clipped = clip;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic signed [OUT_W-1:0] exp_val,
                               input logic signed [OUT_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Track register writes, predict kept pixels and compare each point word in order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_scale = RST_DEPTH_SCALE_RECIP;
            inv_fx      = RST_INV_FOCAL;
            inv_fy      = RST_INV_FOCAL;
            cx          = RST_PRINCIPAL_X;
            cy          = RST_PRINCIPAL_Y;
            ext_row[0]  = RST_EXT_ROW0;
            ext_row[1]  = RST_EXT_ROW1;
            ext_row[2]  = RST_EXT_ROW2;
            expected_points.delete();
            fail_count  = 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_DEPTH_SCALE_RECIP: depth_scale = cfg.data[RECIP_W-1:0];
                    REG_INV_FOCAL_X:       inv_fx      = cfg.data[RECIP_W-1:0];
                    REG_INV_FOCAL_Y:       inv_fy      = cfg.data[RECIP_W-1:0];
                    REG_PRINCIPAL_X:       cx          = cfg.data[PRIN_W-1:0];
                    REG_PRINCIPAL_Y:       cy          = cfg.data[PRIN_W-1:0];
                    REG_EXTRINSIC_ROW0:    ext_row[0]  = cfg.data;
                    REG_EXTRINSIC_ROW1:    ext_row[1]  = cfg.data;
                    REG_EXTRINSIC_ROW2:    ext_row[2]  = cfg.data;
                    default: ;
                endcase
            end

            // Compare before queueing so a stray point never meets a fresh prediction.
            if (point.valid && point.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: point word with none expected, got x=%0d y=%0d z=%0d clipped=%0b",
                             $time, point.point_x, point.point_y, point.point_z, point.clipped);
                    fail_count++;
                end
                else
                begin
                    want        = expected_points.pop_front();
                    got.x       = point.point_x;
                    got.y       = point.point_y;
                    got.z       = point.point_z;
                    got.clipped = point.clipped;
                    check_field("point_x", want.x, got.x);
                    check_field("point_y", want.y, got.y);
                    check_field("point_z", want.z, got.z);
                    check_field("clipped", OUT_W'(want.clipped), OUT_W'(got.clipped));
                end
            end

            if (pixel.valid && pixel.ready)
            begin
                if (project_pixel(pixel.pixel_col, pixel.pixel_row, pixel.depth_raw,
                                  pixel.label_ch1, pixel.label_ch2, pixel.label_ch3,
                                  projected))
                    expected_points.insert(expected_points.size(), projected);
            end

            pending <= expected_points.size();
        end
    end

endmodule

// File: bench/tb_masked_depth_pixel_backprojector.sv
// Stimulus, reset and verdict for the masked depth pixel back-projector.
`timescale 1ns / 100ps

module tb_masked_depth_pixel_backprojector;
    import bpj_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;

    // Receiver behaviors, switched at random over the run.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_CHOKED,
        RX_PERIODIC
    } rx_mode_t;

    logic     clk = 1'b0;
    logic     rst_n;
    int       cycle_count = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       fail_count;
    int       pending;

    bpj_pixel_if pixel_ch ();
    bpj_point_if point_ch ();
    bpj_cfg_if   cfg_ch ();

    masked_depth_pixel_backprojector dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_ch),
        .point (point_ch),
        .cfg   (cfg_ch)
    );

    bpj_point_checker point_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel_ch),
        .point      (point_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // The point receiver stalls on a pattern that changes over the run.
    always @(posedge clk)
    begin
        if (!rst_n)
            point_ch.ready <= 1'b0;
        else
        begin
            if (cycle_count % 300 == 0)
                rx_mode <= rx_mode_t'($urandom_range(RX_OPEN, RX_PERIODIC));
            case (rx_mode)
                RX_OPEN:     point_ch.ready <= 1'b1;
                RX_COIN:     point_ch.ready <= 1'($urandom_range(0, 1));
                RX_CHOKED:   point_ch.ready <= ($urandom_range(0, 3) == 0);
                default:     point_ch.ready <= (cycle_count % 7) < 4;
            endcase
        end
    end

    // Offer one pixel word and hold it until it is taken.
    task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                              input logic [RAW_W-1:0] depth, input logic [LABEL_W-1:0] lab1,
                              input logic [LABEL_W-1:0] lab2, input logic [LABEL_W-1:0] lab3);
        pixel_ch.valid     <= 1'b1;
        pixel_ch.pixel_col <= col;
        pixel_ch.pixel_row <= row;
        pixel_ch.depth_raw <= depth;
        pixel_ch.label_ch1 <= lab1;
        pixel_ch.label_ch2 <= lab2;
        pixel_ch.label_ch3 <= lab3;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
    endtask

    // Write one register; the channel drops for a cycle after each word.
    task automatic cfg_write(input cfg_reg_t idx, input logic [EXT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and wait for every predicted point, then let dropped pixels clear.
    task automatic drain();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_camera(input logic [EXT_W-1:0] scale, input logic [EXT_W-1:0] fx,
                               input logic [EXT_W-1:0] fy, input logic [EXT_W-1:0] px,
                               input logic [EXT_W-1:0] py, input logic [EXT_W-1:0] row0,
                               input logic [EXT_W-1:0] row1, input logic [EXT_W-1:0] row2);
        cfg_write(REG_DEPTH_SCALE_RECIP, scale);
        cfg_write(REG_INV_FOCAL_X, fx);
        cfg_write(REG_INV_FOCAL_Y, fy);
        cfg_write(REG_PRINCIPAL_X, px);
        cfg_write(REG_PRINCIPAL_Y, py);
        cfg_write(REG_EXTRINSIC_ROW0, row0);
        cfg_write(REG_EXTRINSIC_ROW1, row1);
        cfg_write(REG_EXTRINSIC_ROW2, row2);
    endtask

    // Rotation-like row: coefficients within one unit, any translation.
    function automatic logic [EXT_W-1:0] rotation_row();
        int c0;
        int c1;
        int c2;
        c0 = int'($urandom_range(0, 8192)) - 4096;
        c1 = int'($urandom_range(0, 8192)) - 4096;
        c2 = int'($urandom_range(0, 8192)) - 4096;
        return {16'($urandom), 16'(c2), 16'(c1), 16'(c0)};
    endfunction

    // Mostly plausible camera settings, sometimes arbitrary register contents.
    task automatic load_random_camera();
        logic [EXT_W-1:0] rows [3];
        bit               tame;
        tame = ($urandom_range(0, 3) != 0);
        for (int r = 0; r < 3; r++)
            rows[r] = tame ? rotation_row() : {$urandom, $urandom};
        if (tame)
            load_camera(64'($urandom_range(4000, 70000)), 64'($urandom_range(8000, 80000)),
                        64'($urandom_range(8000, 80000)), 64'($urandom_range(0, 16383)),
                        64'($urandom_range(0, 16383)), rows[0], rows[1], rows[2]);
        else
            load_camera({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom}, rows[0], rows[1], rows[2]);
    endtask

    // Most pixels are in the image, labelled and with depth; the rest is noise.
    task automatic send_random_pixel();
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [RAW_W-1:0]   depth;
        logic [LABEL_W-1:0] lab [3];
        if ($urandom_range(0, 99) < 82)
        begin
            col   = COL_W'($urandom_range(0, FRAME_COLS - 1));
            row   = ROW_W'($urandom_range(0, FRAME_ROWS - 1));
            depth = RAW_W'($urandom_range(0, 1) ? $urandom_range(1, 65535)
                                                : $urandom_range(1, 4095));
            for (int k = 0; k < 3; k++)
                lab[k] = $urandom_range(0, 1) ? LABEL_W'($urandom) : '0;
            if (lab[0] == 0 && lab[1] == 0 && lab[2] == 0)
                lab[$urandom_range(0, 2)] = LABEL_W'($urandom_range(1, 65535));
        end
        else
        begin
            col   = COL_W'($urandom);
            row   = ROW_W'($urandom);
            depth = ($urandom_range(0, 3) == 0) ? '0 : RAW_W'($urandom);
            for (int k = 0; k < 3; k++)
                lab[k] = $urandom_range(0, 1) ? '0 : LABEL_W'($urandom);
        end
        send_pixel(col, row, depth, lab[0], lab[1], lab[2]);
    endtask

    // Random pixels in bursts with gaps, with stretches of back-to-back words.
    task automatic run_random(input int count, input bit pause_midway);
        int sent;
        int burst;
        int gap;
        bit steady;
        sent   = 0;
        steady = 1'b0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 20);
            if ($urandom_range(0, 7) == 0)
                steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 6);
            repeat (burst)
            begin
                if (sent < count)
                begin
                    send_random_pixel();
                    sent++;
                    if (pause_midway && sent == count / 2)
                        drain();
                end
            end
            if (gap > 0)
            begin
                pixel_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Timeout guard.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        pixel_ch.valid     = 1'b0;
        pixel_ch.pixel_col = '0;
        pixel_ch.pixel_row = '0;
        pixel_ch.depth_raw = '0;
        pixel_ch.label_ch1 = '0;
        pixel_ch.label_ch2 = '0;
        pixel_ch.label_ch3 = '0;
        point_ch.ready     = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_DEPTH_SCALE_RECIP;
        cfg_ch.data        = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: field extremes, each label channel, dropped pixels.
        send_pixel(0, 0, 1000, 1, 0, 0);
        send_pixel(639, 479, 65535, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(639, 0, 4000, 0, 1, 0);
        send_pixel(0, 479, 4000, 0, 0, 1);
        send_pixel(320, 240, 0, 5, 5, 5);
        send_pixel(320, 240, 3000, 0, 0, 0);
        send_pixel(640, 100, 3000, 1, 1, 1);
        send_pixel(1023, 511, 65535, 1, 1, 1);
        send_pixel(100, 480, 3000, 1, 0, 0);
        send_pixel(512, 256, 16'h8000, 16'h8000, 0, 0);
        send_pixel(1, 1, 1, 0, 16'h8000, 0);
        send_pixel(5, 7, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        run_random(300, 1'b1);
        drain();

        // Every register at an extreme value: deep saturation.
        load_camera(64'h00FF_FFFF, 64'h00FF_FFFF, 64'h00FF_FFFF, 64'h3FFF, 64'h3FFF,
                    64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                    64'hFFFF_FFFF_FFFF_FFFF);
        send_pixel(0, 0, 65535, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(639, 479, 65535, 1, 0, 0);
        send_pixel(0, 0, 1, 0, 0, 1);
        run_random(250, 1'b0);
        drain();

        // Smallest scale, zero focal reciprocals and principal point.
        load_camera(64'd1, 64'd0, 64'd0, 64'd0, 64'd0, 64'h0000_0000_0000_1000,
                    64'h8000_0000_1000_0000, 64'h0);
        send_pixel(10, 10, 255, 1, 0, 0);
        send_pixel(10, 10, 256, 1, 0, 0);
        send_pixel(639, 479, 65535, 0, 0, 1);
        run_random(250, 1'b0);
        drain();

        // Zero depth scale: every pixel is dropped.
        load_camera(64'd0, 64'h00FF_FFFF, 64'd1, 64'h3FFF, 64'd0, rotation_row(),
                    rotation_row(), rotation_row());
        run_random(60, 1'b0);
        drain();

        // Plausible camera back at its power-on intrinsics with a random mount.
        load_camera(64'(RST_DEPTH_SCALE_RECIP), 64'(RST_INV_FOCAL), 64'(RST_INV_FOCAL),
                    64'(RST_PRINCIPAL_X), 64'(RST_PRINCIPAL_Y), rotation_row(),
                    rotation_row(), rotation_row());
        run_random(300, 1'b0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            load_random_camera();
            run_random(200, phase == 1);
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
